// File: sv/deq_pkg.sv
// Shared types, widths and codes for the double-ended queue core.
package deq_pkg;

   localparam int CAPACITY = 1024;
   localparam int POS_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int INDEX_W = 10;
   localparam int COUNT_PORT_W = 11;
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   typedef logic signed [63:0] elem_type;

   typedef enum logic [2:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_READ       = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EOP_HOLD,
      EOP_SHIFT_UP,
      EOP_SHIFT_DOWN,
      EOP_WRITE
   } elem_op_type;

   typedef struct packed {
      elem_op_type           elem_op;
      logic [POS_W-1:0]      wr_pos;
      elem_type              value;
      logic                  shuttle_load;
   } ctl_type;

endpackage

// File: sv/deq_cell.sv
// One storage cell of the queue chain: an element register and a read shuttle register.
module deq_cell (
   input  logic                          clock,
   input  deq_pkg::ctl_type              ctl,
   input  logic [deq_pkg::POS_W-1:0]     my_pos,
   input  deq_pkg::elem_type             left_elem,
   input  deq_pkg::elem_type             right_elem,
   input  deq_pkg::elem_type             right_shuttle,
   output deq_pkg::elem_type             elem,
   output deq_pkg::elem_type             shuttle
);
   import deq_pkg::*;

   elem_type elem_ff;
   elem_type elem_in;
   elem_type shuttle_ff;
   elem_type shuttle_in;

   always_comb begin
      case (ctl.elem_op)
         EOP_HOLD:       elem_in = elem_ff;
         EOP_SHIFT_UP:   elem_in = left_elem;
         EOP_SHIFT_DOWN: elem_in = right_elem;
         EOP_WRITE:      elem_in = (my_pos == ctl.wr_pos) ? ctl.value : elem_ff;
         default:        elem_in = elem_ff;
      endcase
   end

   assign shuttle_in = ctl.shuttle_load ? elem_ff : right_shuttle;

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      shuttle_ff <= shuttle_in;
   end

   assign elem = elem_ff;
   assign shuttle = shuttle_ff;

endmodule

// File: sv/deq_ctrl.sv
// Request decoder, element counter and response sequencer for the queue chain.
module deq_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_action,
   input  deq_pkg::elem_type                    req_value,
   input  logic [deq_pkg::INDEX_W-1:0]          req_index,
   input  deq_pkg::elem_type                    front_elem,
   input  deq_pkg::elem_type                    front_shuttle,
   output deq_pkg::ctl_type                     ctl,
   output logic                                 rsp_strobe,
   output deq_pkg::elem_type                    rsp_data,
   output logic [1:0]                           rsp_status,
   output logic [deq_pkg::COUNT_PORT_W-1:0]     rsp_count
);
   import deq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SEEK
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [POS_W-1:0]       remain_ff, remain_in;
   logic                   strobe_ff, strobe_in;
   elem_type               data_ff, data_in;
   status_type             status_ff, status_in;
   logic [CNT_W-1:0]       rcount_ff, rcount_in;

   logic                   accept;
   logic                   full;
   logic                   empty;
   logic                   in_range;

   assign accept = start && (state_ff == ST_IDLE);
   assign full = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);
   assign in_range = CMP_W'(req_index) < CMP_W'(count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      remain_in = remain_ff;
      strobe_in = 1'b0;
      data_in = '0;
      status_in = STS_OK;
      rcount_in = count_ff;
      ctl.elem_op = EOP_HOLD;
      ctl.wr_pos = POS_W'(count_ff);
      ctl.value = req_value;
      ctl.shuttle_load = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               strobe_in = 1'b1;
               case (req_action)
                  ACT_PUSH_BACK: begin
                     if (full) begin
                        status_in = STS_FULL;
                     end else begin
                        ctl.elem_op = EOP_WRITE;
                        count_in = count_ff + 1'b1;
                        rcount_in = count_ff + 1'b1;
                     end
                  end
                  ACT_PUSH_FRONT: begin
                     if (full) begin
                        status_in = STS_FULL;
                     end else begin
                        ctl.elem_op = EOP_SHIFT_UP;
                        count_in = count_ff + 1'b1;
                        rcount_in = count_ff + 1'b1;
                     end
                  end
                  ACT_POP_BACK: begin
                     if (empty) begin
                        status_in = STS_EMPTY;
                     end else begin
                        strobe_in = 1'b0;
                        ctl.shuttle_load = 1'b1;
                        remain_in = POS_W'(count_ff - 1'b1);
                        count_in = count_ff - 1'b1;
                        state_in = ST_SEEK;
                     end
                  end
                  ACT_POP_FRONT: begin
                     if (empty) begin
                        status_in = STS_EMPTY;
                     end else begin
                        ctl.elem_op = EOP_SHIFT_DOWN;
                        data_in = front_elem;
                        count_in = count_ff - 1'b1;
                        rcount_in = count_ff - 1'b1;
                     end
                  end
                  ACT_READ: begin
                     if (!in_range) begin
                        status_in = STS_RANGE;
                     end else begin
                        strobe_in = 1'b0;
                        ctl.shuttle_load = 1'b1;
                        remain_in = POS_W'(req_index);
                        state_in = ST_SEEK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SEEK: begin
            if (remain_ff == '0) begin
               strobe_in = 1'b1;
               data_in = front_shuttle;
               state_in = ST_IDLE;
            end else begin
               remain_in = remain_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         strobe_ff <= strobe_in;
      end
      remain_ff <= remain_in;
      data_ff <= data_in;
      status_ff <= status_in;
      rcount_ff <= rcount_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data = data_ff;
   assign rsp_status = status_ff;
   assign rsp_count = COUNT_PORT_W'(rcount_ff);

endmodule

// File: sv/double_ended_queue_core.sv
// Top level of the double-ended queue: a chain of element cells and its controller.
//
//   Channel   Direction  Ports                                        Transfer
//   request   in         start, busy, req_action, req_value, req_index  start && !busy
//   response  out        rsp_strobe, rsp_data, rsp_status, rsp_count    rsp_strobe
//
// Elements sit in a row of cells ordered from the front; pushes and front pops shift the
// row or write one cell in the cycle of the transfer, and the response follows in the next
// cycle with busy staying low. A read or a back pop loads every cell's shuttle register
// and shifts the shuttles toward the front until the wanted element reaches the front
// cell, and busy stays high until its response.
// Reset clears the count and the controller; the receiver cannot stall.
module double_ended_queue_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_action,
   input  logic signed [63:0]                   req_value,
   input  logic [deq_pkg::INDEX_W-1:0]          req_index,
   output logic                                 rsp_strobe,
   output logic signed [63:0]                   rsp_data,
   output logic [1:0]                           rsp_status,
   output logic [deq_pkg::COUNT_PORT_W-1:0]     rsp_count
);
   import deq_pkg::*;

   ctl_type   ctl;
   elem_type  elem [CAPACITY];
   elem_type  shuttle [CAPACITY];

   deq_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_value     (req_value),
      .req_index     (req_index),
      .front_elem    (elem[0]),
      .front_shuttle (shuttle[0]),
      .ctl           (ctl),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      elem_type left_elem;
      elem_type right_elem;
      elem_type right_shuttle;

      if (i == 0) begin : g_first
         assign left_elem = ctl.value;
      end else begin : g_mid_left
         assign left_elem = elem[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_elem = '0;
         assign right_shuttle = '0;
      end else begin : g_mid_right
         assign right_elem = elem[i+1];
         assign right_shuttle = shuttle[i+1];
      end

      deq_cell u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .my_pos        (POS_W'(i)),
         .left_elem     (left_elem),
         .right_elem    (right_elem),
         .right_shuttle (right_shuttle),
         .elem          (elem[i]),
         .shuttle       (shuttle[i])
      );
   end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the double-ended queue core with a mirrored queue and scoreboard.
module tb;
   import deq_pkg::*;

   localparam logic [2:0] ACT_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] ACT_LAST_UNUSED  = 3'd7;
   localparam elem_type ELEM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam elem_type ELEM_MIN = 64'sh8000_0000_0000_0000;

   typedef struct {
      elem_type                  data;
      status_type                status;
      logic [COUNT_PORT_W-1:0]   count;
   } deq_response_type;

   class queue_mirror;
      elem_type                slots [CAPACITY];
      logic [POS_W-1:0]        front;
      logic [CNT_W-1:0]        held;
      deq_response_type        due_responses [$];
      int                      failures;
      int                      action_seen [8];
      int                      status_seen [4];
      int                      peak_held;

      function new();
         front = '0;
         held = '0;
         failures = 0;
         peak_held = 0;
         foreach (action_seen[i]) action_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int slot_at(int offset);
         return (int'(front) + offset) % CAPACITY;
      endfunction

      function void note_request(logic [2:0] act, elem_type val, logic [INDEX_W-1:0] idx);
         deq_response_type r;
         r.data = '0;
         r.status = STS_OK;
         case (act)
            ACT_PUSH_BACK: begin
               if (held >= CAPACITY) begin
                  r.status = STS_FULL;
               end else begin
                  slots[slot_at(int'(held))] = val;
                  held++;
               end
            end
            ACT_PUSH_FRONT: begin
               if (held >= CAPACITY) begin
                  r.status = STS_FULL;
               end else begin
                  front = POS_W'(slot_at(CAPACITY - 1));
                  slots[front] = val;
                  held++;
               end
            end
            ACT_POP_BACK: begin
               if (held == 0) begin
                  r.status = STS_EMPTY;
               end else begin
                  r.data = slots[slot_at(int'(held) - 1)];
                  held--;
               end
            end
            ACT_POP_FRONT: begin
               if (held == 0) begin
                  r.status = STS_EMPTY;
               end else begin
                  r.data = slots[front];
                  front = POS_W'(slot_at(1));
                  held--;
               end
            end
            ACT_READ: begin
               if (idx >= held) begin
                  r.status = STS_RANGE;
               end else begin
                  r.data = slots[slot_at(int'(idx))];
               end
            end
            default: begin
            end
         endcase
         r.count = COUNT_PORT_W'(held);
         action_seen[act]++;
         status_seen[r.status]++;
         if (int'(held) > peak_held) peak_held = int'(held);
         due_responses.insert(due_responses.size(), r);
      endfunction

      task report(string what, logic signed [63:0] got, logic signed [63:0] want);
         $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
         failures++;
      endtask

      task check_response(elem_type data, logic [1:0] status, logic [COUNT_PORT_W-1:0] count);
         deq_response_type r;
         if (due_responses.size() == 0) begin
            report("unexpected response, data", data, 0);
         end else begin
            r = due_responses[0];
            due_responses.delete(0);
            if (data !== r.data) report("data", data, r.data);
            if (status !== r.status) report("status", status, r.status);
            if (count !== r.count) report("count", count, r.count);
         end
      endtask

      function int pending();
         return due_responses.size();
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [2:0]                   req_action = ACT_PUSH_BACK;
   logic signed [63:0]           req_value = '0;
   logic [INDEX_W-1:0]           req_index = '0;
   logic                         rsp_strobe;
   logic signed [63:0]           rsp_data;
   logic [1:0]                   rsp_status;
   logic [COUNT_PORT_W-1:0]      rsp_count;

   queue_mirror book = new();
   bit idling_on = 1'b1;

   double_ended_queue_core DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_value(req_value),
      .req_index(req_index),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .rsp_status(rsp_status),
      .rsp_count(rsp_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) book.check_response(rsp_data, rsp_status, rsp_count);
   end

   function elem_type any_value();
      case ($urandom_range(0, 19))
         0: return ELEM_MAX;
         1: return ELEM_MIN;
         2: return '0;
         3: return -64'sd1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer once busy is low.
   task send_request(logic [2:0] act, elem_type val, logic [INDEX_W-1:0] idx);
      while (idling_on && $urandom_range(0, 99) < 10) begin
         start <= 1'b0;
         req_action <= 3'($urandom_range(0, 7));
         req_value <= any_value();
         @(negedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_value <= val;
      req_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      book.note_request(act, val, idx);
      @(negedge clock);
   endtask

   task wait_all_responses();
      start <= 1'b0;
      @(negedge clock);
      while (book.pending() != 0) @(negedge clock);
   endtask

   task send_push();
      send_request($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, any_value(),
                   INDEX_W'($urandom));
   endtask

   task send_pop();
      send_request($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK, any_value(),
                   INDEX_W'($urandom));
   endtask

   task send_read(int hi);
      send_request(ACT_READ, any_value(), INDEX_W'($urandom_range(0, hi)));
   endtask

   task run_directed();
      send_request(ACT_POP_BACK, ELEM_MAX, '0);
      send_request(ACT_POP_FRONT, ELEM_MIN, '1);
      send_request(ACT_READ, '0, '0);
      send_request(ACT_READ, '0, '1);
      send_request(ACT_FIRST_UNUSED, any_value(), INDEX_W'($urandom));
      send_request(ACT_FIRST_UNUSED + 3'd1, any_value(), INDEX_W'($urandom));
      send_request(ACT_LAST_UNUSED, any_value(), INDEX_W'($urandom));
      send_request(ACT_PUSH_BACK, ELEM_MAX, '0);
      send_request(ACT_PUSH_FRONT, ELEM_MIN, '0);
      send_request(ACT_PUSH_BACK, '0, '0);
      send_request(ACT_PUSH_FRONT, -64'sd1, '0);
      send_request(ACT_READ, '0, INDEX_W'(0));
      send_request(ACT_READ, '0, INDEX_W'(3));
      send_request(ACT_READ, '0, INDEX_W'(4));
      send_request(ACT_POP_BACK, '0, '0);
      send_request(ACT_POP_FRONT, '0, '0);
      send_request(ACT_PUSH_BACK, 64'shAAAA_AAAA_AAAA_AAAA, '0);
      send_request(ACT_PUSH_FRONT, 64'sh5555_5555_5555_5555, '0);
      send_request(ACT_READ, '0, INDEX_W'(1));
      send_request(ACT_READ, '0, INDEX_W'(2));
      send_request(ACT_POP_FRONT, '0, '0);
      send_request(ACT_POP_BACK, '0, '0);
      send_request(ACT_POP_BACK, '0, '0);
      send_request(ACT_POP_FRONT, '0, '0);
      send_request(ACT_POP_FRONT, '0, '0);
   endtask

   // Keeps the queue shallow so that reads and back pops stay short.
   task churn_low_occupancy(int n);
      int push_pct;
      int pick;
      for (int i = 0; i < n; i++) begin
         push_pct = (book.held < 8) ? 70 : (book.held > 48) ? 20 : 45;
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            send_request(3'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED)), any_value(),
                         INDEX_W'($urandom));
         end else if ($urandom_range(0, 99) < push_pct) begin
            send_push();
         end else if ($urandom_range(0, 99) < 60) begin
            send_pop();
         end else if ($urandom_range(0, 99) < 90) begin
            send_read(int'(book.held) + 1);
         end else begin
            send_read(CAPACITY - 1);
         end
      end
   endtask

   task fill_to_capacity();
      int pick;
      int done;
      done = 0;
      while (book.held < CAPACITY) begin
         idling_on = (done >= 400);
         pick = $urandom_range(0, 99);
         if (pick < 95 || book.held == 0) begin
            send_push();
         end else if (pick < 99) begin
            send_read(int'(book.held) - 1);
         end else begin
            send_request(ACT_POP_FRONT, any_value(), INDEX_W'($urandom));
         end
         done++;
      end
      idling_on = 1'b1;
   endtask

   task work_at_capacity();
      repeat (3) send_push();
      send_request(ACT_READ, '0, INDEX_W'(CAPACITY - 1));
      send_request(ACT_READ, '0, '0);
      send_read(CAPACITY - 1);
      send_request(ACT_POP_BACK, '0, '0);
      send_request(ACT_PUSH_BACK, ELEM_MIN, '0);
      send_request(ACT_PUSH_FRONT, ELEM_MAX, '0);
      send_request(ACT_POP_FRONT, '0, '0);
      send_request(ACT_PUSH_FRONT, ELEM_MAX, '0);
      send_request(ACT_PUSH_BACK, any_value(), '0);
      send_request(ACT_LAST_UNUSED, any_value(), INDEX_W'($urandom));
      for (int i = 0; i < 40; i++) begin
         if (book.held == CAPACITY || $urandom_range(0, 1)) begin
            if ($urandom_range(0, 3) == 0) send_pop();
            else send_request(ACT_POP_FRONT, any_value(), INDEX_W'($urandom));
         end else if ($urandom_range(0, 4) == 0) begin
            send_read(CAPACITY - 1);
         end else begin
            send_push();
         end
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      wait_all_responses();
      churn_low_occupancy(300);
      wait_all_responses();
      fill_to_capacity();
      work_at_capacity();
      wait_all_responses();
      repeat (1100) @(negedge clock);
      while (book.pending() != 0) begin
         book.report("response never arrived, data", 'x, book.due_responses[0].data);
         book.due_responses.delete(0);
      end
      $display("Ran %0d pushes back, %0d pushes front, %0d pops back, %0d pops front, %0d reads",
               book.action_seen[ACT_PUSH_BACK], book.action_seen[ACT_PUSH_FRONT],
               book.action_seen[ACT_POP_BACK], book.action_seen[ACT_POP_FRONT],
               book.action_seen[ACT_READ]);
      $display("Peak occupancy %0d; ok %0d, empty %0d, full %0d, out of range %0d; %0d failures",
               book.peak_held, book.status_seen[STS_OK], book.status_seen[STS_EMPTY],
               book.status_seen[STS_FULL], book.status_seen[STS_RANGE], book.failures);
      if (book.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Timeout with %0d responses outstanding", book.pending());
      $display("Test completed with failures");
      $finish;
   end

endmodule
